/* design/tss_pkg.sv */
package tss_pkg;

    localparam int unsigned COORD_W     = 5;
    localparam int unsigned GRID_W      = 6;
    localparam int unsigned NTILE_W     = 12;
    localparam int unsigned FULL_MASK_W = 11;
    localparam int unsigned SIZE_W      = 13;
    localparam int unsigned MAXS_W      = 16;
    localparam int unsigned ADD_W       = 16;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned TOTAL_W     = 42;
    localparam int unsigned PIX_W       = 17;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [1:0] REQ_ADVANCE = 2'd0;
    localparam logic [1:0] REQ_ADD     = 2'd1;
    localparam logic [1:0] REQ_QUERY   = 2'd2;
    localparam logic [1:0] REQ_CLEAR   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TILES_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TARGET = 3'd4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [COORD_W-1:0] tile_col;
        logic [COORD_W-1:0] tile_row;
        logic [ADD_W-1:0]   sample_add;
    } t_req;

    typedef struct packed {
        logic [COORD_W-1:0] next_col;
        logic [COORD_W-1:0] next_row;
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic               found;
        logic [COUNT_W-1:0] tile_count;
        logic               all_complete;
        logic [TOTAL_W-1:0] sample_sum;
        logic               status;
    } t_rsp;

    // Effective grid and scaling seen by the datapath
    typedef struct packed {
        logic [GRID_W-1:0]  grid_x;
        logic [GRID_W-1:0]  grid_y;
        logic [NTILE_W-1:0] grid_tiles;
        logic [SIZE_W-1:0]  tile_width;
        logic [SIZE_W-1:0]  tile_height;
        logic [MAXS_W-1:0]  sample_target;
    } t_cfg;

    typedef struct packed {
        logic latch;
        logic rd;
        logic modify;
        logic reject;
        logic adv_start;
        logic adv_eval;
        logic adv_step;
        logic rc_start;
        logic rc_eval;
        logic rc_step;
        logic clr_start;
        logic clr_step;
        logic clr_finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic is_adv;
        logic in_grid;
        logic hit;
        logic adv_last;
        logic rc_last;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

/* design/tss_dp.sv */
module tss_dp #(
    parameter int unsigned MAX_TILES_X = 32,
    parameter int unsigned MAX_TILES_Y = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tss_pkg::t_cfg i_cfg,
    input  tss_pkg::t_cmd i_cmd,
    output tss_pkg::t_sts o_sts,
    input  tss_pkg::t_req i_req,
    input  logic          i_rsp_ready,
    output logic          o_rsp_valid,
    output tss_pkg::t_rsp o_rsp
);
    import tss_pkg::*;

    localparam int unsigned DEPTH = MAX_TILES_X * MAX_TILES_Y;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned PROD_W = GRID_W + SIZE_W;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [PIX_W-1:0]   PIX_MAX   = '1;

    function automatic logic [AW-1:0] slot(input logic [GRID_W-1:0] c,
                                           input logic [GRID_W-1:0] r);
        logic [31:0] idx;
        idx = 32'(r) * 32'(MAX_TILES_X) + 32'(c);
        return idx[AW-1:0];
    endfunction

    // Raster step with wrap; returns {row, col}
    function automatic logic [2*GRID_W-1:0] step_rc(input logic [GRID_W-1:0] c,
                                                    input logic [GRID_W-1:0] r,
                                                    input logic [GRID_W-1:0] gx,
                                                    input logic [GRID_W-1:0] gy);
        logic [GRID_W:0] nc;
        logic [GRID_W:0] nr;
        nc = {1'b0, c} + 1'b1;
        nr = {1'b0, r};
        if (nc >= {1'b0, gx}) begin
            nc = '0;
            nr = nr + 1'b1;
        end
        if (nr >= {1'b0, gy}) begin
            nr = '0;
        end
        return {nr[GRID_W-1:0], nc[GRID_W-1:0]};
    endfunction

    logic [COUNT_W-1:0] mem [DEPTH];

    logic [1:0]          r_type;
    logic [COORD_W-1:0]  r_col;
    logic [COORD_W-1:0]  r_row;
    logic [ADD_W-1:0]    r_add;
    logic [GRID_W-1:0]   r_c, n_c;
    logic [GRID_W-1:0]   r_r, n_r;
    logic [NTILE_W-1:0]  r_visit, n_visit;
    logic [AW-1:0]       r_clr;
    logic [COUNT_W-1:0]  r_rd_data;
    logic [TOTAL_W-1:0]  r_total;
    logic [NTILE_W-1:0]  r_full, n_full;
    logic [GRID_W-1:0]   r_nc;
    logic [GRID_W-1:0]   r_nr;
    logic                r_found;
    logic [COUNT_W-1:0]  r_count;
    logic                r_status;
    logic                r_rsp_valid;
    t_rsp                r_rsp;

    logic [2*GRID_W-1:0] cur_nxt;
    logic [2*GRID_W-1:0] req_nxt;
    logic [GRID_W-1:0]   col_ext;
    logic [GRID_W-1:0]   row_ext;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [COUNT_W-1:0]  mem_wdata;
    logic                is_add;
    logic [COUNT_W-1:0]  max_ext;
    logic                hit;
    logic [COUNT_W:0]    add_sum;
    logic [COUNT_W-1:0]  add_val;
    logic [COUNT_W-1:0]  add_delta;
    logic [TOTAL_W:0]    tot_sum;
    logic [TOTAL_W-1:0]  tot_val;
    logic                crosses;
    logic [PROD_W-1:0]   prod_x;
    logic [PROD_W-1:0]   prod_y;
    logic                out_free;

    assign col_ext = GRID_W'(r_col);
    assign row_ext = GRID_W'(r_row);
    assign cur_nxt = step_rc(r_c, r_r, i_cfg.grid_x, i_cfg.grid_y);
    assign req_nxt = step_rc(col_ext, row_ext, i_cfg.grid_x, i_cfg.grid_y);
    assign is_add  = (r_type == REQ_ADD);
    assign max_ext = COUNT_W'(i_cfg.sample_target);
    assign hit     = (r_rd_data < max_ext);

    // Saturating count update and the amount it really adds to the total
    assign add_sum   = {1'b0, r_rd_data} + (COUNT_W + 1)'(r_add);
    assign add_val   = add_sum[COUNT_W] ? COUNT_MAX : add_sum[COUNT_W-1:0];
    assign add_delta = add_val - r_rd_data;
    assign tot_sum   = {1'b0, r_total} + (TOTAL_W + 1)'(add_delta);
    assign tot_val   = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
    assign crosses   = hit && (add_val >= max_ext);

    always_comb begin
        n_c     = r_c;
        n_r     = r_r;
        n_visit = r_visit;
        if (i_cmd.rd) begin
            n_c = col_ext;
            n_r = row_ext;
        end else if (i_cmd.adv_start) begin
            {n_r, n_c} = req_nxt;
            n_visit    = NTILE_W'(1);
        end else if (i_cmd.rc_start) begin
            n_c = '0;
            n_r = '0;
        end else if (i_cmd.adv_step || i_cmd.rc_step) begin
            {n_r, n_c} = cur_nxt;
            if (i_cmd.adv_step) begin
                n_visit = r_visit + 1'b1;
            end
        end
    end

    // Read every cycle at the position about to be held
    assign rd_addr   = slot(n_c, n_r);
    assign mem_we    = i_cmd.clr_step || (i_cmd.modify && is_add);
    assign mem_waddr = i_cmd.clr_step ? r_clr : slot(r_c, r_r);
    assign mem_wdata = i_cmd.clr_step ? '0 : add_val;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_full = r_full;
        if (i_cmd.clr_finish) begin
            n_full = (i_cfg.sample_target == '0) ? i_cfg.grid_tiles : '0;
        end else if (i_cmd.rc_start) begin
            n_full = '0;
        end else if ((i_cmd.rc_eval && !hit) || (i_cmd.modify && is_add && crosses)) begin
            n_full = r_full + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c         <= '0;
            r_r         <= '0;
            r_visit     <= '0;
            r_clr       <= '0;
            r_total     <= '0;
            r_full      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_c     <= n_c;
            r_r     <= n_r;
            r_visit <= n_visit;
            r_full  <= n_full;
            if (i_cmd.clr_start) begin
                r_clr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.clr_finish) begin
                r_total <= '0;
            end else if (i_cmd.modify && is_add) begin
                r_total <= tot_val;
            end
            if (i_cmd.out_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_type <= i_req.req_type;
            r_col  <= i_req.tile_col;
            r_row  <= i_req.tile_row;
            r_add  <= i_req.sample_add;
        end
        if (i_cmd.reject || i_cmd.clr_finish) begin
            r_nc     <= col_ext;
            r_nr     <= row_ext;
            r_found  <= 1'b0;
            r_count  <= '0;
            r_status <= i_cmd.reject;
        end else if (i_cmd.modify) begin
            r_nc     <= r_c;
            r_nr     <= r_r;
            r_found  <= 1'b0;
            r_count  <= is_add ? add_val : r_rd_data;
            r_status <= 1'b0;
        end else if (i_cmd.adv_eval) begin
            r_nc     <= r_c;
            r_nr     <= r_r;
            r_found  <= hit;
            r_count  <= r_rd_data;
            r_status <= 1'b0;
        end
    end

    assign prod_x = PROD_W'(r_nc) * PROD_W'(i_cfg.tile_width);
    assign prod_y = PROD_W'(r_nr) * PROD_W'(i_cfg.tile_height);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rsp.next_col     <= r_nc[COORD_W-1:0];
            r_rsp.next_row     <= r_nr[COORD_W-1:0];
            r_rsp.pixel_x      <= (prod_x > PROD_W'(PIX_MAX)) ? PIX_MAX : prod_x[PIX_W-1:0];
            r_rsp.pixel_y      <= (prod_y > PROD_W'(PIX_MAX)) ? PIX_MAX : prod_y[PIX_W-1:0];
            r_rsp.found        <= r_found;
            r_rsp.tile_count   <= r_count;
            r_rsp.all_complete <= (NTILE_W'(r_full[FULL_MASK_W-1:0]) == i_cfg.grid_tiles);
            r_rsp.sample_sum   <= r_total;
            r_rsp.status       <= r_status;
        end
    end

    assign out_free = !r_rsp_valid || i_rsp_ready;

    assign o_sts.is_clear = (r_type == REQ_CLEAR);
    assign o_sts.is_adv   = (r_type == REQ_ADVANCE);
    assign o_sts.in_grid  = (col_ext < i_cfg.grid_x) && (row_ext < i_cfg.grid_y);
    assign o_sts.hit      = hit;
    assign o_sts.adv_last = (r_visit == i_cfg.grid_tiles);
    assign o_sts.rc_last  = (r_c == i_cfg.grid_x - 1'b1) && (r_r == i_cfg.grid_y - 1'b1);
    assign o_sts.clr_last = (r_clr == AW'(DEPTH - 1));
    assign o_sts.out_free = out_free;

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

/* design/tss_ctrl.sv */
module tss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_touch,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  tss_pkg::t_sts i_sts,
    output tss_pkg::t_cmd o_cmd
);
    import tss_pkg::*;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DISP = 3'd2;
    localparam logic [2:0] ST_MOD  = 3'd3;
    localparam logic [2:0] ST_ADV  = 3'd4;
    localparam logic [2:0] ST_RC   = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_rc_pend, n_rc_pend;
    logic       r_clr_rsp, n_clr_rsp;
    logic       rc_go;
    t_cmd       cmd;

    always_comb begin
        n_state   = r_state;
        n_clr_rsp = r_clr_rsp;
        rc_go     = 1'b0;
        cmd       = '0;
        case (r_state)
            ST_CLR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    cmd.clr_finish = 1'b1;
                    n_clr_rsp      = 1'b0;
                    n_state        = r_clr_rsp ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (r_rc_pend) begin
                    cmd.rc_start = 1'b1;
                    rc_go        = 1'b1;
                    n_state      = ST_RC;
                end else if (i_req_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = ST_DISP;
                end
            end
            ST_DISP: begin
                if (i_sts.is_clear) begin
                    cmd.clr_start = 1'b1;
                    n_clr_rsp     = 1'b1;
                    n_state       = ST_CLR;
                end else if (!i_sts.in_grid) begin
                    cmd.reject = 1'b1;
                    n_state    = ST_OUT;
                end else if (i_sts.is_adv) begin
                    cmd.adv_start = 1'b1;
                    n_state       = ST_ADV;
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                cmd.modify = 1'b1;
                n_state    = ST_OUT;
            end
            ST_ADV: begin
                cmd.adv_eval = 1'b1;
                if (i_sts.hit || i_sts.adv_last) begin
                    n_state = ST_OUT;
                end else begin
                    cmd.adv_step = 1'b1;
                end
            end
            ST_RC: begin
                cmd.rc_eval = 1'b1;
                if (i_sts.rc_last) begin
                    n_state = ST_IDLE;
                end else begin
                    cmd.rc_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold a recount request until the scan starts; a later write re-arms it
    assign n_rc_pend = i_cfg_touch || (r_rc_pend && !rc_go);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_rc_pend <= 1'b0;
            r_clr_rsp <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rc_pend <= n_rc_pend;
            r_clr_rsp <= n_clr_rsp;
        end
    end

    assign o_req_ready = (r_state == ST_IDLE) && !r_rc_pend;
    assign o_cmd       = cmd;

endmodule

/* design/tile_sample_scheduler.sv */
// Channel   Direction  Handshake                    Payload
// request   in         i_req_valid / o_req_ready    i_req  (tss_pkg::t_req)
// result    out        o_rsp_valid / i_rsp_ready    o_rsp  (tss_pkg::t_rsp)
// config    in         i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// Add and query requests pass the dispatch, modify and output states; off-grid ones skip modify.
// Advance walks the tiles after the given one in raster order, visiting 1 .. tiles_x*tiles_y tiles,
// one store read each. Clear zeroes all MAX_TILES_X*MAX_TILES_Y store entries, one per cycle.
// Reset runs the same clearing pass before the first request is taken. A write to tiles_x,
// tiles_y or the sample target holds off requests for a recount over every tile of the grid.
// A stalled result waits in the output register; only the next result's final load stalls.
module tile_sample_scheduler #(
    parameter int unsigned MAX_TILES_X = 32,
    parameter int unsigned MAX_TILES_Y = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tss_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tss_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_req_valid,
    output logic                               o_req_ready,
    input  tss_pkg::t_req                      i_req,
    output logic                               o_rsp_valid,
    input  logic                               i_rsp_ready,
    output tss_pkg::t_rsp                      o_rsp
);
    import tss_pkg::*;

    // Configuration registers
    logic [GRID_W-1:0] r_tiles_x;
    logic [GRID_W-1:0] r_tiles_y;
    logic [SIZE_W-1:0] r_tile_width;
    logic [SIZE_W-1:0] r_tile_height;
    logic [MAXS_W-1:0] r_sample_target;

    logic [GRID_W-1:0] grid_x;
    logic [GRID_W-1:0] grid_y;
    logic              cfg_touch;
    t_cfg              cfg;
    t_cmd              cmd;
    t_sts              sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles_x       <= GRID_W'(1);
            r_tiles_y       <= GRID_W'(1);
            r_tile_width    <= SIZE_W'(16);
            r_tile_height   <= SIZE_W'(16);
            r_sample_target <= MAXS_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TILES_X:       r_tiles_x       <= i_cfg_data[GRID_W-1:0];
                CFG_TILES_Y:       r_tiles_y       <= i_cfg_data[GRID_W-1:0];
                CFG_TILE_WIDTH:    r_tile_width    <= i_cfg_data[SIZE_W-1:0];
                CFG_TILE_HEIGHT:   r_tile_height   <= i_cfg_data[SIZE_W-1:0];
                CFG_SAMPLE_TARGET: r_sample_target <= i_cfg_data[MAXS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Anything that moves the grid or the full threshold invalidates the full-tile count
    assign cfg_touch = i_cfg_we && ((i_cfg_idx == CFG_TILES_X) ||
                                    (i_cfg_idx == CFG_TILES_Y) ||
                                    (i_cfg_idx == CFG_SAMPLE_TARGET));

    // Clamp the grid: zero acts as one, oversize acts as the store's limit
    always_comb begin
        if (r_tiles_x == '0) begin
            grid_x = GRID_W'(1);
        end else if (32'(r_tiles_x) > 32'(MAX_TILES_X)) begin
            grid_x = GRID_W'(MAX_TILES_X);
        end else begin
            grid_x = r_tiles_x;
        end
        if (r_tiles_y == '0) begin
            grid_y = GRID_W'(1);
        end else if (32'(r_tiles_y) > 32'(MAX_TILES_Y)) begin
            grid_y = GRID_W'(MAX_TILES_Y);
        end else begin
            grid_y = r_tiles_y;
        end
    end

    assign cfg.grid_x        = grid_x;
    assign cfg.grid_y        = grid_y;
    assign cfg.grid_tiles    = NTILE_W'(grid_x) * NTILE_W'(grid_y);
    assign cfg.tile_width    = r_tile_width;
    assign cfg.tile_height   = r_tile_height;
    assign cfg.sample_target = r_sample_target;

    tss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_touch (cfg_touch),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tss_dp #(
        .MAX_TILES_X (MAX_TILES_X),
        .MAX_TILES_Y (MAX_TILES_Y)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_req),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

/* bench/tile_sample_scheduler_test.sv */
module tile_sample_scheduler_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    localparam int unsigned GRID_MAX      = 32;
    localparam int unsigned STORE_DEPTH   = GRID_MAX * GRID_MAX;
    // Covers the clearing pass after reset and the full-tile recount after a write
    localparam int unsigned SETTLE_CYCLES = STORE_DEPTH + 76;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned DRAIN_CYCLES  = 50;
    localparam int unsigned CYCLE_LIMIT   = 8_000_000;
    localparam int unsigned PHASES        = 10;
    localparam int unsigned PHASE_ITEMS   = 140;
    localparam logic [TOTAL_W-1:0] TOTAL_SAT = {TOTAL_W{1'b1}};
    localparam logic [PIX_W-1:0]   PIX_SAT   = {PIX_W{1'b1}};

    // Per-tile sample tally and the results it implies, in request order
    class tally_scoreboard;
        bit [GRID_W-1:0]  reg_cols;
        bit [GRID_W-1:0]  reg_rows;
        bit [SIZE_W-1:0]  reg_width;
        bit [SIZE_W-1:0]  reg_height;
        bit [MAXS_W-1:0]  reg_max;
        bit [COUNT_W-1:0] tally [STORE_DEPTH];
        bit [TOTAL_W-1:0] total;
        bit [COORD_W-1:0] last_col;
        bit [COORD_W-1:0] last_row;
        t_rsp             expected_q [$];
        int unsigned      mismatches;
        int unsigned      checked;
        int unsigned      exhausted;

        function new();
            foreach (tally[i]) tally[i] = '0;
            total      = '0;
            reg_cols   = 1;
            reg_rows   = 1;
            reg_width  = 16;
            reg_height = 16;
            reg_max    = 1;
            last_col   = '0;
            last_row   = '0;
            mismatches = 0;
            checked    = 0;
            exhausted  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TILES_X:       reg_cols   = data[GRID_W-1:0];
                CFG_TILES_Y:       reg_rows   = data[GRID_W-1:0];
                CFG_TILE_WIDTH:    reg_width  = data[SIZE_W-1:0];
                CFG_TILE_HEIGHT:   reg_height = data[SIZE_W-1:0];
                CFG_SAMPLE_TARGET: reg_max    = data[MAXS_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned grid_cols();
            if (reg_cols == 0) return 1;
            return (reg_cols > GRID_MAX) ? GRID_MAX : reg_cols;
        endfunction

        function int unsigned grid_rows();
            if (reg_rows == 0) return 1;
            return (reg_rows > GRID_MAX) ? GRID_MAX : reg_rows;
        endfunction

        function logic [PIX_W-1:0] pixel_offset(logic [COORD_W-1:0] t, bit [SIZE_W-1:0] size);
            longint unsigned p;
            p = longint'(t) * longint'(size);
            return (p > longint'(PIX_SAT)) ? PIX_SAT : p[PIX_W-1:0];
        endfunction

        function void note_request(t_req r);
            t_rsp             e;
            int unsigned      gx, gy, c, rw, n, full, slot;
            bit [COUNT_W-1:0] old_v, new_v;
            bit [TOTAL_W:0]   sum;
            gx = grid_cols();
            gy = grid_rows();
            e = '0;
            e.next_col = r.tile_col;
            e.next_row = r.tile_row;
            slot = r.tile_row * GRID_MAX + r.tile_col;
            if (r.req_type == REQ_CLEAR) begin
                foreach (tally[i]) tally[i] = '0;
                total = '0;
            end else if (r.tile_col >= gx || r.tile_row >= gy) begin
                e.status = 1'b1;
            end else if (r.req_type == REQ_ADVANCE) begin
                // Walk raster order from the tile after the given one, wrapping once
                c  = r.tile_col;
                rw = r.tile_row;
                for (n = 0; n < gx * gy; n++) begin
                    c++;
                    if (c >= gx) begin
                        c = 0;
                        rw++;
                    end
                    if (rw >= gy) rw = 0;
                    if (tally[rw * GRID_MAX + c] < reg_max) begin
                        e.found = 1'b1;
                        break;
                    end
                end
                if (!e.found) exhausted++;
                e.next_col   = c[COORD_W-1:0];
                e.next_row   = rw[COORD_W-1:0];
                e.tile_count = tally[rw * GRID_MAX + c];
                last_col     = e.next_col;
                last_row     = e.next_row;
            end else if (r.req_type == REQ_ADD) begin
                old_v = tally[slot];
                new_v = (old_v > ({COUNT_W{1'b1}} - r.sample_add)) ? {COUNT_W{1'b1}}
                                                                  : old_v + r.sample_add;
                tally[slot] = new_v;
                // Grow the total only by what the tile actually took
                sum = {1'b0, total} + (TOTAL_W+1)'(new_v - old_v);
                total = (sum > {1'b0, TOTAL_SAT}) ? TOTAL_SAT : sum[TOTAL_W-1:0];
                e.tile_count = new_v;
            end else begin
                e.tile_count = tally[slot];
            end
            full = 0;
            for (rw = 0; rw < gy; rw++)
                for (c = 0; c < gx; c++)
                    if (tally[rw * GRID_MAX + c] >= reg_max) full++;
            e.all_complete = (full == gx * gy);
            e.pixel_x      = pixel_offset(e.next_col, reg_width);
            e.pixel_y      = pixel_offset(e.next_row, reg_height);
            e.sample_sum   = total;
            expected_q.push_back(e);
        endfunction

        function void check_response(t_rsp got);
            t_rsp e;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.next_col !== e.next_col) begin
                $error("next_col: expected %0d, actual %0d", e.next_col, got.next_col);
                mismatches++;
            end
            if (got.next_row !== e.next_row) begin
                $error("next_row: expected %0d, actual %0d", e.next_row, got.next_row);
                mismatches++;
            end
            if (got.pixel_x !== e.pixel_x) begin
                $error("pixel_x: expected %0d, actual %0d", e.pixel_x, got.pixel_x);
                mismatches++;
            end
            if (got.pixel_y !== e.pixel_y) begin
                $error("pixel_y: expected %0d, actual %0d", e.pixel_y, got.pixel_y);
                mismatches++;
            end
            if (got.found !== e.found) begin
                $error("found: expected %0d, actual %0d", e.found, got.found);
                mismatches++;
            end
            if (got.tile_count !== e.tile_count) begin
                $error("tile_count: expected %0d, actual %0d", e.tile_count, got.tile_count);
                mismatches++;
            end
            if (got.all_complete !== e.all_complete) begin
                $error("all_complete: expected %0d, actual %0d",
                       e.all_complete, got.all_complete);
                mismatches++;
            end
            if (got.sample_sum !== e.sample_sum) begin
                $error("sample_sum: expected %0d, actual %0d",
                       e.sample_sum, got.sample_sum);
                mismatches++;
            end
            if (got.status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_req_valid;
    logic                  o_req_ready;
    t_req                  i_req;
    logic                  o_rsp_valid;
    logic                  i_rsp_ready;
    t_rsp                  o_rsp;

    tally_scoreboard sb;
    bit              no_idle;
    bit              hold_results;
    int unsigned     sent;
    int unsigned     settings;
    int unsigned     cycles;

    tile_sample_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bound the run: a hang anywhere ends in failure
    initial begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic t_req make_req(logic [1:0] kind, int unsigned col, int unsigned row,
                                      logic [ADD_W-1:0] add);
        t_req r;
        r.req_type   = kind;
        r.tile_col   = col[COORD_W-1:0];
        r.tile_row   = row[COORD_W-1:0];
        r.sample_add = add;
        return r;
    endfunction

    // Mostly renderer-like traffic inside the grid, with some noise coordinates
    function automatic t_req random_request();
        t_req        r;
        int unsigned roll, gx, gy;
        gx = sb.grid_cols();
        gy = sb.grid_rows();
        roll = $urandom_range(0, 99);
        if (roll < 3)       r.req_type = REQ_CLEAR;
        else if (roll < 38) r.req_type = REQ_ADVANCE;
        else if (roll < 78) r.req_type = REQ_ADD;
        else                r.req_type = REQ_QUERY;
        // Small adds fill tiles toward the sample target; wide ones toggle every bit
        if ($urandom_range(0, 9) < 6) r.sample_add = ADD_W'($urandom_range(0, sb.reg_max));
        else                          r.sample_add = ADD_W'($urandom);
        if ($urandom_range(0, 99) < 10) begin
            r.tile_col = COORD_W'($urandom);
            r.tile_row = COORD_W'($urandom);
        end else if (r.req_type == REQ_ADD && $urandom_range(0, 1)) begin
            // Render into the tile that the last advance handed out
            r.tile_col = sb.last_col;
            r.tile_row = sb.last_row;
        end else begin
            r.tile_col = COORD_W'($urandom_range(0, gx - 1));
            r.tile_row = COORD_W'($urandom_range(0, gy - 1));
        end
        return r;
    endfunction

    // Entered right after a falling edge; returns right after one
    task automatic send_request(input t_req r, input int unsigned gap);
        if (gap != 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (o_req_ready !== 1'b1);
        sb.note_request(r);
        sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every outstanding request has its result
    task automatic wait_idle();
        i_req_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        sb.write_reg(idx, CFG_DATA_W'(value));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        // Let any full-tile recount finish before the next write
        repeat (SETTLE_CYCLES - 1) @(negedge i_clk);
    endtask

    task automatic configure(input int unsigned cols, input int unsigned rows,
                             input int unsigned width, input int unsigned height,
                             input int unsigned target);
        wait_idle();
        write_reg(CFG_TILES_X, cols);
        write_reg(CFG_TILES_Y, rows);
        write_reg(CFG_TILE_WIDTH, width);
        write_reg(CFG_TILE_HEIGHT, height);
        write_reg(CFG_SAMPLE_TARGET, target);
        settings++;
    endtask

    // Result side: random back-pressure, plus one long hold-off on demand
    initial begin
        int unsigned gap;
        i_rsp_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_results) begin
                hold_results = 1'b0;
                gap = LONG_HOLD;
            end else begin
                gap = draw_gap();
            end
            if (gap != 0) begin
                i_rsp_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_rsp_ready <= 1'b1;
            do @(posedge i_clk); while (o_rsp_valid !== 1'b1);
            sb.check_response(o_rsp);
            @(negedge i_clk);
        end
    end

    initial begin
        int unsigned ph, n, failures, span;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_req_valid  = 1'b0;
        i_req        = '0;
        no_idle      = 1'b0;
        hold_results = 1'b0;
        sent         = 0;
        settings     = 0;
        sb = new();

        // Hold reset, then wait out the clearing pass
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        // 2x2 grid, wide tiles so that off-grid echoes saturate the pixel offset
        configure(2, 2, 8191, 4096, 2);
        send_request(make_req(REQ_QUERY,   1,  1, 16'h0000), draw_gap());
        send_request(make_req(REQ_ADD,     0,  0, 16'hFFFF), draw_gap());
        send_request(make_req(REQ_ADD,     1,  0, 16'h0001), draw_gap());
        send_request(make_req(REQ_ADVANCE, 0,  0, 16'h0000), draw_gap());
        send_request(make_req(REQ_ADD,     1,  0, 16'h0001), draw_gap());
        send_request(make_req(REQ_ADD,     0,  1, 16'h0002), draw_gap());
        send_request(make_req(REQ_ADVANCE, 1,  0, 16'h0000), draw_gap());
        send_request(make_req(REQ_ADD,     1,  1, 16'hFFFF), draw_gap());
        // Every tile full: advance must hand back its own starting tile
        send_request(make_req(REQ_ADVANCE, 1,  1, 16'hFFFF), draw_gap());
        // Coordinates off the grid for each request that looks at a tile
        send_request(make_req(REQ_QUERY,  31, 31, 16'h0000), draw_gap());
        send_request(make_req(REQ_ADD,     2,  0, 16'h0005), draw_gap());
        send_request(make_req(REQ_ADVANCE, 0,  2, 16'h0000), draw_gap());
        send_request(make_req(REQ_CLEAR,  31, 31, 16'hFFFF), draw_gap());
        // Wrap from the last tile back to the first
        send_request(make_req(REQ_ADVANCE, 1,  1, 16'h0000), draw_gap());
        send_request(make_req(REQ_ADD,     0,  0, 16'h5555), draw_gap());
        send_request(make_req(REQ_ADD,     1,  1, 16'hAAAA), draw_gap());

        // Out-of-range grid sizes clamp to 1 column and 32 rows; zero target means all full.
        // Tiles left outside the shrunken grid still count toward the total.
        configure(0, 63, 1, 1, 0);
        send_request(make_req(REQ_ADVANCE, 0,  5, 16'h0000), draw_gap());
        send_request(make_req(REQ_QUERY,   1,  0, 16'h0000), draw_gap());
        send_request(make_req(REQ_ADD,     0, 31, 16'h0007), draw_gap());
        send_request(make_req(REQ_QUERY,   0, 31, 16'h0000), draw_gap());

        // Largest grid and largest target: wrap past a full tile at the grid end
        configure(32, 32, 4096, 1, 65535);
        send_request(make_req(REQ_ADVANCE, 31, 31, 16'h0000), draw_gap());
        send_request(make_req(REQ_ADD,     31, 31, 16'hFFFF), draw_gap());
        send_request(make_req(REQ_ADVANCE, 30, 31, 16'h0000), draw_gap());

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: configure(32, 32, 4096, 4096, $urandom_range(1, 3));
                1: configure(1, 1, 1, 1, 1);
                2: configure(32, 1, $urandom_range(1, 4096), 4096, $urandom_range(1, 4));
                3: configure(1, 32, 1, $urandom_range(1, 4096), $urandom_range(1, 4));
                4: configure($urandom_range(1, 8), $urandom_range(1, 8), 8191, 8191, 65535);
                default: configure($urandom_range(1, 8), $urandom_range(1, 8),
                                   $urandom_range(1, 4096), $urandom_range(1, 4096),
                                   ($urandom_range(0, 9) == 0) ? 65535
                                                               : $urandom_range(1, 40));
            endcase
            // Keep the full grid short: every clear and long scan there visits each of its tiles
            span = (ph == 0) ? PHASE_ITEMS / 2 : PHASE_ITEMS + PHASE_ITEMS / 14;
            for (n = 0; n < span; n++) begin
                // Run a stretch back to back on both sides
                if (n == 50) no_idle = 1'b1;
                if (n == 80) no_idle = 1'b0;
                // Starve the result side so the block backs up into the request side
                if (ph == 2 && n == 20) hold_results = 1'b1;
                // Pause requests until every result is home
                if (n == 100) wait_idle();
                send_request(random_request(), draw_gap());
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        failures = sb.mismatches + sb.expected_q.size();
        $display("Sent %0d requests over %0d register settings; %0d results checked.",
                 sent, settings, sb.checked);
        $display("Advances with every tile full: %0d; sample total at end: %0d.",
                 sb.exhausted, sb.total);
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
